// ===== src/pled_pkg.sv =====
// Shared types and constants for the positional list editor.
// Holds the command and response words, the op and status codes and the cell control word.
// No dependencies.
`timescale 1ns / 1ps

package pled_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int MAX_CAPACITY = 64;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 8;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 2;
  // wide enough for any cell index and for a count of MAX_CAPACITY
  localparam int IDX_W        = $clog2(MAX_CAPACITY + 1);

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
  localparam logic [OP_W-1:0] OP_REVERSE = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    value_t           item_value;
    logic [POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    value_t              elem_value;
    logic                has_value;
    logic [STATUS_W-1:0] status;
    logic                last;
  } rsp_t;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_DELETE,
    ACT_ROT_DN,
    ACT_ROT_UP
  } cell_act_t;

  typedef struct packed {
    cell_act_t        act;
    logic [IDX_W-1:0] pos;
    value_t           value;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

endpackage

// ===== src/positional_list_editor_unit.sv =====
// Top level of the positional list editor: control, ring of cells and response register.
// Depends on pled_pkg and pled_cell.
//
//  channel | direction | handshake            | word
//  cmd     | in        | cmd_valid / cmd_stall | pled_pkg::cmd_t (op, item_value, position)
//  rsp     | out       | rsp_valid / rsp_stall | pled_pkg::rsp_t (elem_value, has_value, status, last)
//
// Append, delete and insert shift every cell in parallel; reverse only flips the reversal flag.
// A non-empty dump rotates the ring one cell per step, a full turn past the head or tail
// tap, so the cells end where they began; a step is held while an element word is due
// and the response register is stalled.
// Commands are held off for the whole dump and whenever the response register is stalled.
// Reset clears the count, the reversal flag, the state, the step counter and the response valid.
// Cell contents are not reset; only cells below the count are ever read.
`timescale 1ns / 1ps

module positional_list_editor_unit #(
  parameter int CAPACITY = pled_pkg::DEF_CAPACITY
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  pled_pkg::cmd_t  cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output pled_pkg::rsp_t  rsp
);
  import pled_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [CW-1:0] LAST_C = CW'(CAPACITY - 1);

  // control registers
  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic          rev, rev_next;
  logic [CW-1:0] step, step_next;

  // response register
  logic rsp_valid_next;
  rsp_t rsp_next;

  logic       accept;
  logic       slot_free;
  logic       load;
  logic       emit;
  logic       advance;
  cell_ctrl_t ctrl;
  value_t     cell_q [CAPACITY];

  // decode helpers, compared in one bit more than the position field
  logic [POS_W:0] pos9, cnt9;
  logic [POS_W:0] p_app, p_ins, p_del;
  logic [CW-1:0]  emit_from;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign pos9      = {1'b0, cmd.position};
  assign cnt9      = (POS_W + 1)'(count);
  assign p_app     = rev ? '0 : cnt9;
  assign p_ins     = rev ? (cnt9 - pos9 + 1'b1) : (pos9 - 1'b1);
  assign p_del     = rev ? (cnt9 - pos9) : (pos9 - 1'b1);
  assign emit_from = CAP_C - count;

  // forward order leaves from cell 0 while rotating down; reversed order first
  // rotates the unused cells past the tail, then leaves from the last cell
  assign emit    = (state == S_DUMP) && (rev ? (step >= emit_from) : (step < count));
  assign advance = (state == S_DUMP) && (!emit || slot_free);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && cmd.op == OP_DUMP && count != '0) begin
          state_next = S_DUMP;
        end
      end
      S_DUMP: begin
        if (advance && step == LAST_C) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cmd_stall  = (state == S_DUMP) || !slot_free;
    count_next = count;
    rev_next   = rev;
    step_next  = step;
    load       = 1'b0;
    rsp_next   = rsp;
    ctrl.act   = ACT_HOLD;
    ctrl.pos   = '0;
    ctrl.value = cmd.item_value;
    case (state)
      S_IDLE: begin
        if (accept) begin
          rsp_next.elem_value = '0;
          rsp_next.has_value  = 1'b0;
          rsp_next.status     = ST_OK;
          rsp_next.last       = 1'b1;
          load                = 1'b1;
          case (cmd.op)
            OP_APPEND: begin
              if (count == CAP_C) begin
                rsp_next.status = ST_FULL;
              end else begin
                ctrl.act   = ACT_INSERT;
                ctrl.pos   = IDX_W'(p_app);
                count_next = count + 1'b1;
              end
            end
            OP_DELETE: begin
              if (count == '0) begin
                rsp_next.status = ST_EMPTY;
              end else if (pos9 == '0 || pos9 > cnt9) begin
                rsp_next.status = ST_BADPOS;
              end else begin
                ctrl.act   = ACT_DELETE;
                ctrl.pos   = IDX_W'(p_del);
                count_next = count - 1'b1;
              end
            end
            OP_INSERT: begin
              if (pos9 == '0 || pos9 > cnt9 + 1'b1) begin
                rsp_next.status = ST_BADPOS;
              end else if (count == CAP_C) begin
                rsp_next.status = ST_FULL;
              end else begin
                ctrl.act   = ACT_INSERT;
                ctrl.pos   = IDX_W'(p_ins);
                count_next = count + 1'b1;
              end
            end
            OP_REVERSE: rev_next = !rev;
            OP_DUMP: begin
              // an empty dump answers at once; otherwise start the rotation
              if (count != '0) begin
                load      = 1'b0;
                step_next = '0;
              end
            end
            default: load = 1'b0;
          endcase
        end
      end
      S_DUMP: begin
        if (advance) begin
          ctrl.act  = rev ? ACT_ROT_UP : ACT_ROT_DN;
          step_next = step + 1'b1;
          if (emit) begin
            load                = 1'b1;
            rsp_next.elem_value = rev ? cell_q[CAPACITY-1] : cell_q[0];
            rsp_next.has_value  = 1'b1;
            rsp_next.status     = ST_OK;
            rsp_next.last       = rev ? (step == LAST_C) : (step == count - 1'b1);
          end
        end
      end
      default: ;
    endcase
  end

  // hold the word until taken, drop valid once it leaves
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rev       <= 1'b0;
      step      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rev       <= rev_next;
      step      <= step_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  // ring of cells: the ends close on each other for the dump rotation
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pled_cell #(
      .INDEX(i)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .lower(cell_q[(i + CAPACITY - 1) % CAPACITY]),
      .upper(cell_q[(i + 1) % CAPACITY]),
      .value(cell_q[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("element count above capacity");

  a_dump_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> cmd_stall)
    else $error("command taken during dump");

  a_count_stable_dump: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |=> count == $past(count))
    else $error("count changed during dump");

  a_edit_answer: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.op == OP_APPEND || cmd.op == OP_DELETE || cmd.op == OP_INSERT ||
                cmd.op == OP_REVERSE))
    |=> (rsp_valid && rsp.last && !rsp.has_value))
    else $error("edit produced no status word");

endmodule

// ===== src/pled_cell.sv =====
// One storage cell of the list chain.
// Takes its own value, its neighbours' values or the broadcast value; depends on pled_pkg.
`timescale 1ns / 1ps

module pled_cell #(
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  pled_pkg::cell_ctrl_t ctrl,
  input  pled_pkg::value_t     lower,
  input  pled_pkg::value_t     upper,
  output pled_pkg::value_t     value
);
  import pled_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  value_t value_next;

  always_comb begin
    value_next = value;
    case (ctrl.act)
      ACT_INSERT: begin
        if (MY_IDX > ctrl.pos) begin
          value_next = lower;
        end else if (MY_IDX == ctrl.pos) begin
          value_next = ctrl.value;
        end
      end
      ACT_DELETE: begin
        if (MY_IDX >= ctrl.pos) begin
          value_next = upper;
        end
      end
      ACT_ROT_DN: value_next = upper;
      ACT_ROT_UP: value_next = lower;
      default:    value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
